@@ src/zzs_pkg.sv @@
// shared constants, types and microcode table for the zigzag matrix scan
package zzs_pkg;

    localparam int MAX_SIDE    = 8;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 4;
    localparam int RESET_SIDE  = 8;
    localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
    localparam int RC_W        = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    typedef enum logic [1:0] {
        STEP_LOAD,
        STEP_OUT,
        STEP_NEXT
    } step_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_FULL,
        COND_OUT_FREE,
        COND_DONE
    } cond_t;

    typedef struct packed {
        logic in_ready;
        logic scan_clr;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic full;
        logic out_free;
        logic done;
    } status_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t target;
        step_t alt;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{ctrl: '{in_ready: 1'b0, scan_clr: 1'b0, emit: 1'b0},
              cond: COND_ALWAYS, target: STEP_LOAD, alt: STEP_LOAD};
        case (step)
            STEP_LOAD: begin
                w.ctrl.in_ready = 1'b1;
                w.ctrl.scan_clr = 1'b1;
                w.cond          = COND_FULL;
                w.target        = STEP_NEXT;
                w.alt           = STEP_LOAD;
            end
            STEP_OUT: begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_OUT_FREE;
                w.target    = STEP_NEXT;
                w.alt       = STEP_OUT;
            end
            STEP_NEXT: begin
                w.cond   = COND_DONE;
                w.target = STEP_LOAD;
                w.alt    = STEP_OUT;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_LOAD;
                w.alt    = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

    function automatic logic [SIDE_W-1:0] side_clamp(input logic [CFG_W-1:0] s);
        logic [SIDE_W-1:0] r;
        if (s == '0) begin
            r = SIDE_W'(1);
        end else if (int'(s) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = SIDE_W'(s);
        end
        return r;
    endfunction

endpackage

@@ src/zzs_ram.sv @@
// generic single-write, single-read ram with registered read data
module zzs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          aclk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/zzs_seq.sv @@
// microcode sequencer: step counter, control rom and conditional jumps
module zzs_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  zzs_pkg::status_t status,
    output zzs_pkg::ctrl_t   ctrl
);
    import zzs_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   cond_true;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        word = ucode_rom(step_reg);
        ctrl = word.ctrl;
        case (word.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_FULL:     cond_true = status.full;
            COND_OUT_FREE: cond_true = status.out_free;
            COND_DONE:     cond_true = status.done;
            default:       cond_true = 1'b1;
        endcase
        step_next = cond_true ? word.target : word.alt;
    end

endmodule

@@ src/zigzag_matrix_scan.sv @@
// top level: zigzag scan of a square matrix, datapath plus sequencer and store
//
// Elements arrive row-major, one per cycle while s_tready is high, and are
// written into a 64-word store. The transfer that completes the matrix starts
// the scan: inputs are held off while the n*n elements leave in zigzag order,
// each result taking a store read and then an output register load, an order
// set by the single read port and the per-result advance of the scan position;
// loading resumes once the last result is issued. Output stalls hold the scan.
// The final result carries tlast. The output register lets loading of the
// next matrix begin while the last result still waits. Writing side_length
// (0 acts as 1, values above 8 act as 8) drops any partly loaded matrix.
module zigzag_matrix_scan (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [zzs_pkg::CFG_W-1:0]           cfg_wr_data,   // side_length
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [zzs_pkg::DATA_W-1:0]   s_tdata,       // element_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [zzs_pkg::DATA_W-1:0]   m_tdata,       // scan_value
    output logic                                m_tlast
);
    import zzs_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    logic [SIDE_W-1:0] side_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  load_cnt_reg;
    logic [RC_W-1:0]   row_reg;
    logic [RC_W-1:0]   col_reg;
    logic [CNT_W-1:0]  k_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [RC_W-1:0]   row_next;
    logic [RC_W-1:0]   col_next;
    logic [RC_W-1:0]   side_m1;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              in_xfer;
    logic              count_full;
    logic              out_free;
    logic              emit_go;

    zzs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    zzs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (in_xfer),
        .wr_addr (load_cnt_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready   = ctrl.in_ready;
    assign in_xfer    = s_tvalid && ctrl.in_ready;
    assign count_full = (CNT_W'(load_cnt_reg + 1'b1) == total_reg);
    assign out_free   = !out_valid_reg || m_tready;
    assign emit_go    = ctrl.emit && out_free;

    assign status.full     = in_xfer && count_full;
    assign status.out_free = out_free;
    assign status.done     = (k_reg == total_reg);

    assign side_m1 = RC_W'(side_reg - SIDE_W'(1));
    assign rd_addr = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(side_reg) + ADDR_W'(col_reg));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // zigzag position update
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if ((row_reg[0] ^ col_reg[0]) == 1'b0) begin
            if (col_reg == side_m1) begin
                row_next = row_reg + 1'b1;
            end else if (row_reg == '0) begin
                col_next = col_reg + 1'b1;
            end else begin
                row_next = row_reg - 1'b1;
                col_next = col_reg + 1'b1;
            end
        end else begin
            if (row_reg == side_m1) begin
                col_next = col_reg + 1'b1;
            end else if (col_reg == '0) begin
                row_next = row_reg + 1'b1;
            end else begin
                row_next = row_reg + 1'b1;
                col_next = col_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg     <= side_clamp(CFG_W'(RESET_SIDE));
            total_reg    <= CNT_W'(RESET_SIDE * RESET_SIDE);
            load_cnt_reg <= '0;
        end else if (cfg_wr_en) begin
            side_reg     <= side_clamp(cfg_wr_data);
            total_reg    <= CNT_W'(side_clamp(cfg_wr_data) * side_clamp(cfg_wr_data));
            load_cnt_reg <= '0;
        end else if (in_xfer) begin
            load_cnt_reg <= count_full ? '0 : CNT_W'(load_cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            k_reg   <= '0;
        end else if (ctrl.scan_clr) begin
            row_reg <= '0;
            col_reg <= '0;
            k_reg   <= '0;
        end else if (emit_go) begin
            row_reg <= row_next;
            col_reg <= col_next;
            k_reg   <= CNT_W'(k_reg + 1'b1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            out_data_reg <= rd_data;
            out_last_reg <= (CNT_W'(k_reg + 1'b1) == total_reg);
        end
    end

endmodule

@@ bench/zzs_scan_checker.sv @@
// checker for the zigzag matrix scan: predicts scan results from observed transfers and compares
`timescale 1ns / 100ps

module zzs_scan_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [zzs_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic signed [zzs_pkg::DATA_W-1:0]   s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic signed [zzs_pkg::DATA_W-1:0]   m_tdata,
    input  logic                                m_tlast,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_seen
);

    typedef struct packed {
        logic signed [zzs_pkg::DATA_W-1:0] value;
        logic                              last;
    } scan_word_t;

    scan_word_t predicted_scan[$];
    scan_word_t expected;

    logic signed [zzs_pkg::DATA_W-1:0] element_grid [zzs_pkg::STORE_DEPTH];
    logic [zzs_pkg::CFG_W-1:0]         side_code;
    int                                fill_count;
    int                                n;

    function automatic int active_side(input logic [zzs_pkg::CFG_W-1:0] code);
        int s;
        s = int'(code);
        if (s == 0) begin
            s = 1;
        end else if (s > zzs_pkg::MAX_SIDE) begin
            s = zzs_pkg::MAX_SIDE;
        end
        return s;
    endfunction

    // walk the anti-diagonals, alternating direction
    task automatic predict_zigzag(input int side);
        int d;
        int k;
        int lo;
        int hi;
        int r;
        int c;
        scan_word_t w;
        for (d = 0; d <= 2 * side - 2; d++) begin
            lo = (d >= side) ? d - side + 1 : 0;
            hi = (d < side) ? d : side - 1;
            for (k = 0; k <= hi - lo; k++) begin
                r = (d % 2 == 0) ? hi - k : lo + k;
                c = d - r;
                w.value = element_grid[r * side + c];
                w.last  = (d == 2 * side - 2);
                predicted_scan.push_back(w);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            side_code    = zzs_pkg::CFG_W'(zzs_pkg::RESET_SIDE);
            fill_count   = 0;
            mismatches   = 0;
            results_seen = 0;
            predicted_scan.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (predicted_scan.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result transfer, expected none, got value %0d last %0b",
                             $time, m_tdata, m_tlast);
                end else begin
                    expected = predicted_scan.pop_front();
                    if (m_tdata !== expected.value) begin
                        mismatches++;
                        $display("%0t: scan_value mismatch, expected %0d, got %0d",
                                 $time, expected.value, m_tdata);
                    end
                    if (m_tlast !== expected.last) begin
                        mismatches++;
                        $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                                 $time, expected.last, m_tlast);
                    end
                end
            end
            // a register write drops any partly loaded matrix
            if (cfg_wr_en) begin
                side_code  = cfg_wr_data;
                fill_count = 0;
            end
            if (s_tvalid && s_tready) begin
                n = active_side(side_code);
                element_grid[fill_count] = s_tdata;
                fill_count++;
                if (fill_count == n * n) begin
                    predict_zigzag(n);
                    fill_count = 0;
                end
            end
        end
        outstanding = predicted_scan.size();
    end

endmodule

@@ bench/tb_zigzag_matrix_scan.sv @@
// testbench top for the zigzag matrix scan: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_zigzag_matrix_scan;

    localparam int ELEMENT_TARGET = 420;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int LONG_HOLD      = 300;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    logic [zzs_pkg::CFG_W-1:0]           cfg_wr_data;
    logic                                s_tvalid;
    logic                                s_tready;
    logic signed [zzs_pkg::DATA_W-1:0]   s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic signed [zzs_pkg::DATA_W-1:0]   m_tdata;
    logic                                m_tlast;

    int mismatches;
    int outstanding;
    int results_seen;

    int cycle_count    = 0;
    int elements_sent  = 0;
    int side_writes    = 0;
    int burst_left     = 0;
    logic long_hold_req  = 1'b0;
    logic long_hold_done = 1'b0;

    zigzag_matrix_scan uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    zzs_scan_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d results still due",
                     $time, cycle_count, outstanding);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: stall pattern in segments, plus one long hold-off
    initial begin
        int ready_pct;
        int seg_left;
        ready_pct = 100;
        seg_left  = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            if (seg_left == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
                seg_left = $urandom_range(16, 96);
            end
            seg_left--;
            m_tready = ($urandom_range(1, 100) <= ready_pct);
        end
    end

    function automatic logic signed [zzs_pkg::DATA_W-1:0] pick_element();
        logic signed [zzs_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 11))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2: v = -32'sd1;
            3: v = 32'sd0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // sender: offers one element, idling between bursts
    task automatic push_element(input logic signed [zzs_pkg::DATA_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
            if ($urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(30, 80);
            end else begin
                burst_left = $urandom_range(1, 12);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        elements_sent++;
    endtask

    // side_length is only written once all due results are out
    task automatic set_side(input logic [zzs_pkg::CFG_W-1:0] code);
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = code;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        side_writes++;
    endtask

    task automatic push_matrices(input int side, input int count);
        int i;
        for (i = 0; i < count * side * side; i++) begin
            push_element(pick_element());
        end
    endtask

    initial begin
        int r;
        int side;
        int i;
        logic [zzs_pkg::CFG_W-1:0] code;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // partial matrix under the reset side, dropped by the next write
        push_element(32'sd11);
        push_element(-32'sd12);
        push_element(32'sd13);
        set_side(4'd1);
        push_element(32'sh7fffffff);
        push_element(32'sh80000000);
        push_element(32'sd0);
        // zero side acts as one
        set_side(4'd0);
        push_element(-32'sd1);
        set_side(4'd2);
        push_element(32'sh80000000);
        push_element(32'sh7fffffff);
        push_element(-32'sd1);
        push_element(32'sd0);
        push_element(32'sd21);
        push_element(-32'sd22);
        set_side(4'd3);
        for (i = 1; i <= 9; i++) begin
            push_element((i % 2 == 0) ? -i : i);
        end

        // long receiver hold-off while several small matrices are offered
        set_side(4'd2);
        @(posedge aclk);
        long_hold_req = 1'b1;
        @(negedge aclk);
        push_matrices(2, 4);
        // side above the maximum saturates
        set_side(4'd15);
        push_matrices(8, 1);

        while (elements_sent < ELEMENT_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                side = 1;
            end else if (r < 45) begin
                side = 2;
            end else if (r < 67) begin
                side = 3;
            end else if (r < 84) begin
                side = 4;
            end else if (r < 94) begin
                side = $urandom_range(5, 7);
            end else begin
                side = 8;
            end
            if (side == 1) begin
                code = zzs_pkg::CFG_W'($urandom_range(0, 1));
            end else if (side == 8) begin
                code = zzs_pkg::CFG_W'($urandom_range(8, 15));
            end else begin
                code = zzs_pkg::CFG_W'(side);
            end
            set_side(code);
            push_matrices(side, (side > 5) ? 1 : $urandom_range(1, 3));
            if (side > 1 && $urandom_range(0, 9) == 0) begin
                r = $urandom_range(1, side * side - 1);
                for (i = 0; i < r; i++) begin
                    push_element(pick_element());
                end
            end
        end

        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        $display("covered %0d elements, %0d scan results, %0d side settings, one long output stall",
                 elements_sent, results_seen, side_writes);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
